// File: hw/rtl/tns_pkg.sv
// Shared types and constants for the tune note sequencer.
// Used by tns_seq and tune_note_sequencer_top; depends on nothing.
package tns_pkg;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 6;
    localparam int TONE_W  = 4;
    localparam int DUR_W   = 8;
    localparam int ENTRY_W = TONE_W + DUR_W;
    localparam int LEN_W   = 7;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFGI_W  = 1;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 8;

    localparam logic [TONE_W-1:0] SILENT_TONE   = 4'd12;
    localparam logic [LEN_W-1:0]  LEN_RESET     = 7'd1;
    localparam logic [CNT_W-1:0]  PLAYS_RESET   = 8'd1;

    localparam logic [CFGI_W-1:0] CFG_TUNE_LENGTH = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_PLAY_COUNT  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_START   = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4
    } t_op;

    // What one accepted item did, carried to the result stage.
    typedef struct packed {
        logic snd;      // a note was read; tone arrives from the store
        logic changed;
        logic playing;
    } t_step;

endpackage

// File: hw/rtl/tns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module tns_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tns_seq.sv
// Sequencer state and per-item decision: plays, note pointer, countdown, tone.
// Depends on tns_pkg; drives the note store ports of tns_ram through the top.
module tns_seq #(
    parameter int MAX_NOTES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tns_pkg::CFGI_W-1:0]        i_cfg_idx,
    input  logic [tns_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_accept,
    input  logic [tns_pkg::OP_W-1:0]          i_op,
    input  logic [tns_pkg::IDX_W-1:0]         i_note_index,
    input  logic [tns_pkg::TONE_W-1:0]        i_note_tone,
    input  logic [tns_pkg::DUR_W-1:0]         i_note_duration,
    input  logic                              i_pend,
    input  logic [tns_pkg::ENTRY_W-1:0]       i_rdata,
    output logic                              o_we,
    output logic [((MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1)-1:0] o_waddr,
    output logic [tns_pkg::ENTRY_W-1:0]       o_wdata,
    output logic                              o_re,
    output logic [((MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1)-1:0] o_raddr,
    output tns_pkg::t_step                    o_step,
    output logic [tns_pkg::TONE_W-1:0]        o_tone
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int NW = $clog2(MAX_NOTES + 1);
    localparam int CW = (NW > tns_pkg::LEN_W) ? NW : tns_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_NOTES);

    logic [tns_pkg::LEN_W-1:0]  r_tune_length;
    logic [tns_pkg::CNT_W-1:0]  r_play_count;
    logic [NW-1:0]              r_next_note, n_next_note;
    logic [tns_pkg::CNT_W-1:0]  r_plays_left, n_plays_left;
    logic [tns_pkg::DUR_W-1:0]  r_ticks, n_ticks;
    logic                       r_armed, n_armed;
    logic                       r_enabled, n_enabled;
    logic [tns_pkg::TONE_W-1:0] r_tone, n_tone;

    logic [tns_pkg::TONE_W-1:0] eff_tone;
    logic [tns_pkg::DUR_W-1:0]  eff_ticks;
    logic [CW-1:0]              len_c;
    logic [CW-1:0]              len_eff;
    logic [tns_pkg::TONE_W-1:0] ld_tone;

    // Forward the note still in flight from the store.
    assign eff_tone  = i_pend ? i_rdata[tns_pkg::TONE_W-1:0] : r_tone;
    assign eff_ticks = i_pend ? i_rdata[tns_pkg::ENTRY_W-1:tns_pkg::TONE_W] : r_ticks;
    assign len_c     = CW'(r_tune_length);
    assign len_eff   = (len_c > MAX_C) ? MAX_C : len_c;
    assign ld_tone   = (i_note_tone > tns_pkg::SILENT_TONE) ? tns_pkg::SILENT_TONE
                                                            : i_note_tone;

    always_comb begin
        n_next_note  = r_next_note;
        n_plays_left = r_plays_left;
        n_ticks      = eff_ticks;
        n_armed      = r_armed;
        n_enabled    = r_enabled;
        n_tone       = eff_tone;
        o_we         = 1'b0;
        o_waddr      = AW'(i_note_index);
        o_wdata      = {i_note_duration, ld_tone};
        o_re         = 1'b0;
        o_raddr      = AW'(r_next_note);
        o_step       = '0;
        if (i_accept) begin
            case (tns_pkg::t_op'(i_op))
                tns_pkg::OP_TICK: begin
                    if (r_enabled) begin
                        if (r_armed) begin
                            n_armed      = 1'b0;
                            n_plays_left = r_play_count - 1'b1;
                            o_re         = 1'b1;
                            o_raddr      = '0;
                            n_next_note  = NW'(1);
                            o_step.snd   = 1'b1;
                            o_step.changed = 1'b1;
                        end else if (eff_ticks != '0) begin
                            n_ticks = eff_ticks - 1'b1;
                        end else if (CW'(r_next_note) >= len_eff) begin
                            if (r_plays_left == '0) begin
                                n_enabled = 1'b0;
                                n_tone    = tns_pkg::SILENT_TONE;
                            end else begin
                                n_plays_left = r_plays_left - 1'b1;
                                o_re         = 1'b1;
                                o_raddr      = '0;
                                n_next_note  = NW'(1);
                                o_step.snd   = 1'b1;
                            end
                            o_step.changed = 1'b1;
                        end else begin
                            o_re           = 1'b1;
                            n_next_note    = r_next_note + 1'b1;
                            o_step.snd     = 1'b1;
                            o_step.changed = 1'b1;
                        end
                    end
                end
                tns_pkg::OP_LOAD: begin
                    // Drop loads aimed past the store.
                    o_we = (CW'(i_note_index) < MAX_C);
                end
                tns_pkg::OP_START:   n_armed   = 1'b1;
                tns_pkg::OP_ENABLE:  n_enabled = 1'b1;
                tns_pkg::OP_DISABLE: n_enabled = 1'b0;
                default: ;
            endcase
            o_step.playing = n_enabled;
        end
    end

    assign o_tone = r_tone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tune_length <= tns_pkg::LEN_RESET;
            r_play_count  <= tns_pkg::PLAYS_RESET;
            r_next_note   <= '0;
            r_plays_left  <= '0;
            r_ticks       <= '0;
            r_armed       <= 1'b0;
            r_enabled     <= 1'b0;
            r_tone        <= tns_pkg::SILENT_TONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tns_pkg::CFG_TUNE_LENGTH: r_tune_length <= i_cfg_wdata[tns_pkg::LEN_W-1:0];
                    tns_pkg::CFG_PLAY_COUNT:  r_play_count  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_next_note  <= n_next_note;
            r_plays_left <= n_plays_left;
            r_ticks      <= n_ticks;
            r_armed      <= n_armed;
            r_enabled    <= n_enabled;
            r_tone       <= n_tone;
        end
    end

endmodule

// File: hw/rtl/tune_note_sequencer_top.sv
// Tune note sequencer: plays a tune from a note store, one tick per item.
// An accepted item is held in the result stage while the store read completes,
// then moves to the output register. Throughput: one item per cycle; a note read from
// the store is forwarded to the following item. Input stalls only on output stall.
// Reset (i_rst_n low, synchronous): idle, disabled, tone silent, registers at
// their defaults; the note store keeps its contents and is undefined until loaded.
module tune_note_sequencer_top #(
    parameter int MAX_NOTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [tns_pkg::CFGI_W-1:0]    i_cfg_idx,
    input  logic [tns_pkg::CFG_W-1:0]     i_cfg_wdata,
    // Input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] op
    input  logic [tns_pkg::OP_W-1:0]      s_axis_tuser,
    // [5:0] note_index, [9:6] note_tone, [17:10] note_duration, [23:18] zero
    input  logic [tns_pkg::IN_W-1:0]      s_axis_tdata,
    // Result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] tone, [4] tone_changed, [5] playing, [7:6] zero
    output logic [tns_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    logic                         accept;
    logic                         p_adv;
    logic                         r_p_v;
    tns_pkg::t_step               r_p, step;
    logic                         r_o_v;
    logic [tns_pkg::TONE_W-1:0]   r_o_tone;
    logic                         r_o_changed;
    logic                         r_o_playing;

    logic                         we, re;
    logic [AW-1:0]                waddr, raddr;
    logic [tns_pkg::ENTRY_W-1:0]  wdata, rdata;
    logic [tns_pkg::TONE_W-1:0]   cur_tone;

    // The result stage moves on when the output register is free or drained;
    // take a new item whenever the result stage is empty or can move on.
    assign p_adv         = r_p_v && (!r_o_v || m_axis_tready);
    assign s_axis_tready = !r_p_v || p_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tns_seq #(
        .MAX_NOTES (MAX_NOTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_op            (s_axis_tuser),
        .i_note_index    (s_axis_tdata[5:0]),
        .i_note_tone     (s_axis_tdata[9:6]),
        .i_note_duration (s_axis_tdata[17:10]),
        .i_pend          (r_p_v && r_p.snd),
        .i_rdata         (rdata),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_re            (re),
        .o_raddr         (raddr),
        .o_step          (step),
        .o_tone          (cur_tone)
    );

    // Note store: duration in the upper bits, tone in the lower.
    tns_ram #(
        .WIDTH (tns_pkg::ENTRY_W),
        .DEPTH (MAX_NOTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result stage: hold the step while the store read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_p   <= '0;
        end else if (accept) begin
            r_p_v <= 1'b1;
            r_p   <= step;
        end else if (p_adv) begin
            r_p_v <= 1'b0;
            r_p   <= '0;
        end
    end

    // Output register: a sounded note takes its tone straight from the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (p_adv) begin
            r_o_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_tone    <= r_p.snd ? rdata[tns_pkg::TONE_W-1:0] : cur_tone;
            r_o_changed <= r_p.changed;
            r_o_playing <= r_p.playing;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {2'b00, r_o_playing, r_o_changed, r_o_tone};

endmodule
